// File: rtl/core/nsp_pkg.sv
// Shared widths, codes and bundle types for the nine-slice pixel mapper.
// No dependencies; every other file in rtl/core refers to this package.
package nsp_pkg;

    localparam int COORD_BITS   = 12;
    localparam int NUM_STATES   = 4;
    localparam int PIX_BITS     = COORD_BITS + 1;
    localparam int SRCX_BITS    = COORD_BITS + 2;
    localparam int SKIN_BITS    = 4;
    localparam int BASE_BITS    = SKIN_BITS + COORD_BITS;
    localparam int ZONE_BITS    = 4;
    localparam int STATUS_BITS  = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int REM_STAGES   = COORD_BITS;  // one remainder bit per stage
    localparam int ZONE_COLS    = 3;

    localparam logic [SKIN_BITS:0] STATE_LIMIT = (SKIN_BITS + 1)'(NUM_STATES);
    localparam logic [ZONE_BITS-1:0] ZONE_LAST = ZONE_BITS'(8);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RECT_LEFT    = 3'd0,
        REG_RECT_TOP     = 3'd1,
        REG_RECT_WIDTH   = 3'd2,
        REG_RECT_HEIGHT  = 3'd3,
        REG_CORNER_SIZE  = 3'd4,
        REG_PATCH_WIDTH  = 3'd5,
        REG_PATCH_HEIGHT = 3'd6,
        REG_IMAGE_STATUS = 3'd7
    } t_cfg_reg;

    // position along one axis: corner, stretched middle, far corner
    typedef enum logic [1:0] {
        THIRD_NEAR = 2'd0,
        THIRD_MID  = 2'd1,
        THIRD_FAR  = 2'd2
    } t_third;

    // configuration plus values derived from it
    typedef struct packed {
        logic [COORD_BITS-1:0]  left;
        logic [COORD_BITS-1:0]  top;
        logic [COORD_BITS-1:0]  width;
        logic [COORD_BITS-1:0]  height;
        logic [COORD_BITS-1:0]  pw;
        logic [COORD_BITS-1:0]  ph;
        logic [STATUS_BITS-1:0] status;
        logic [COORD_BITS-1:0]  cw;      // clamped corner, x
        logic [COORD_BITS-1:0]  ch;      // clamped corner, y
        logic [COORD_BITS-1:0]  off_x;   // pw - width, modular
        logic [COORD_BITS-1:0]  off_y;   // ph - height, modular
        logic [COORD_BITS-1:0]  span_x;  // middle source width
        logic [COORD_BITS-1:0]  span_y;  // middle source height
    } t_geom;

    // per-pixel data riding alongside the remainder stages
    typedef struct packed {
        logic                  kill;
        logic                  use_mask;
        logic [BASE_BITS-1:0]  base;
        t_third                col;
        t_third                row;
        logic [COORD_BITS-1:0] edge_x;
        logic [COORD_BITS-1:0] edge_y;
    } t_side;

endpackage

// File: rtl/core/nsp_cfg.sv
// Configuration registers and the clamped corner / span values derived from them.
// Depends on nsp_pkg.
module nsp_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr,
    input  logic [nsp_pkg::CFG_IDX_BITS-1:0]      i_index,
    input  logic [nsp_pkg::COORD_BITS-1:0]        i_data,
    output nsp_pkg::t_geom                        o_geom
);

    localparam int CB = nsp_pkg::COORD_BITS;

    logic [CB-1:0] r_left, r_top, r_width, r_height, r_corner, r_pw, r_ph;
    logic [nsp_pkg::STATUS_BITS-1:0] r_status;

    // first derived rank
    logic [CB-1:0] r_cw, r_ch, r_off_x, r_off_y;
    logic [CB-1:0] n_cw, n_ch, n_off_x, n_off_y;
    // second derived rank
    logic [CB-1:0] r_span_x, r_span_y;
    logic [CB-1:0] n_span_x, n_span_y;

    logic [CB-1:0] min_a, min_x, min_y;

    function automatic logic [CB-1:0] min2(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a < b) ? a : b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_corner <= '0;
            r_pw     <= '0;
            r_ph     <= '0;
            r_status <= '0;
        end else if (i_wr) begin
            unique case (nsp_pkg::t_cfg_reg'(i_index))
                nsp_pkg::REG_RECT_LEFT:    r_left   <= i_data;
                nsp_pkg::REG_RECT_TOP:     r_top    <= i_data;
                nsp_pkg::REG_RECT_WIDTH:   r_width  <= i_data;
                nsp_pkg::REG_RECT_HEIGHT:  r_height <= i_data;
                nsp_pkg::REG_CORNER_SIZE:  r_corner <= i_data;
                nsp_pkg::REG_PATCH_WIDTH:  r_pw     <= i_data;
                nsp_pkg::REG_PATCH_HEIGHT: r_ph     <= i_data;
                nsp_pkg::REG_IMAGE_STATUS: r_status <= i_data[nsp_pkg::STATUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequential clamps collapse to one min over all limits.
    always_comb begin
        min_a    = min2(r_corner, r_pw >> 1);
        min_x    = min2(r_ph >> 1, r_width >> 1);
        min_y    = min2(r_ph >> 1, r_height >> 1);
        n_cw     = min2(min_a, min_x);
        n_ch     = min2(min_a, min_y);
        n_off_x  = r_pw - r_width;
        n_off_y  = r_ph - r_height;
        n_span_x = r_pw - (r_cw << 1);
        n_span_y = r_ph - (r_ch << 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw     <= '0;
            r_ch     <= '0;
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_span_x <= '0;
            r_span_y <= '0;
        end else begin
            r_cw     <= n_cw;
            r_ch     <= n_ch;
            r_off_x  <= n_off_x;
            r_off_y  <= n_off_y;
            r_span_x <= n_span_x;
            r_span_y <= n_span_y;
        end
    end

    always_comb begin
        o_geom.left   = r_left;
        o_geom.top    = r_top;
        o_geom.width  = r_width;
        o_geom.height = r_height;
        o_geom.pw     = r_pw;
        o_geom.ph     = r_ph;
        o_geom.status = r_status;
        o_geom.cw     = r_cw;
        o_geom.ch     = r_ch;
        o_geom.off_x  = r_off_x;
        o_geom.off_y  = r_off_y;
        o_geom.span_x = r_span_x;
        o_geom.span_y = r_span_y;
    end

endmodule

// File: rtl/core/nsp_front.sv
// Front stages: input capture, rectangle test and offsets, zone classification.
// Depends on nsp_pkg; feeds nsp_rem.
module nsp_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [nsp_pkg::PIX_BITS-1:0]          i_pixel_x,
    input  logic [nsp_pkg::PIX_BITS-1:0]          i_pixel_y,
    input  logic [nsp_pkg::SKIN_BITS-1:0]         i_skin_state,
    input  logic                                  i_opaque,
    input  nsp_pkg::t_geom                        i_geom,
    output logic                                  o_valid,
    output nsp_pkg::t_side                        o_side,
    output logic [nsp_pkg::COORD_BITS-1:0]        o_m_x,
    output logic [nsp_pkg::COORD_BITS-1:0]        o_m_y
);

    localparam int CB = nsp_pkg::COORD_BITS;
    localparam int PB = nsp_pkg::PIX_BITS;
    localparam int BB = nsp_pkg::BASE_BITS;

    typedef struct packed {
        nsp_pkg::t_third third;
        logic [CB-1:0]   edge_src;
        logic [CB-1:0]   m;
    } t_axis;

    function automatic t_axis classify(input logic [CB-1:0] d, input logic [CB-1:0] len,
                                       input logic [CB-1:0] c, input logic [CB-1:0] off);
        t_axis     a;
        logic [CB:0] reach;
        reach = {1'b0, d} + {1'b0, c};
        a.m   = d - c;
        if (d < c) begin
            a.third    = nsp_pkg::THIRD_NEAR;
            a.edge_src = d;
        end else if (reach >= {1'b0, len}) begin
            a.third    = nsp_pkg::THIRD_FAR;
            a.edge_src = d + off;  // d + pw - len
        end else begin
            a.third    = nsp_pkg::THIRD_MID;
            a.edge_src = d;
        end
        return a;
    endfunction

    // stage A: captured word
    logic                          r_a_v;
    logic [PB-1:0]                 r_a_px, r_a_py;
    logic [nsp_pkg::SKIN_BITS-1:0] r_a_st;
    logic                          r_a_opq;

    // stage B: offsets inside the rectangle, early rejects
    logic          r_b_v, r_b_kill, r_b_mask;
    logic [CB-1:0] r_b_dx, r_b_dy;
    logic [BB-1:0] r_b_base;
    logic          n_b_kill, n_b_mask;
    logic [CB-1:0] n_b_dx, n_b_dy;
    logic [BB-1:0] n_b_base;
    logic [PB-1:0] right_end, bottom_end;
    logic          in_x, in_y;

    // stage C
    logic           r_c_v;
    nsp_pkg::t_side r_c_side, n_c_side;
    logic [CB-1:0]  r_c_mx, r_c_my;
    t_axis          ax, ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_comb begin
        right_end  = {1'b0, i_geom.left} + {1'b0, i_geom.width};
        bottom_end = {1'b0, i_geom.top} + {1'b0, i_geom.height};
        in_x = (r_a_px >= {1'b0, i_geom.left}) && (r_a_px < right_end);
        in_y = (r_a_py >= {1'b0, i_geom.top}) && (r_a_py < bottom_end);
        n_b_dx = CB'(r_a_px - {1'b0, i_geom.left});
        n_b_dy = CB'(r_a_py - {1'b0, i_geom.top});
        n_b_kill = (i_geom.width == '0) || (i_geom.height == '0)
                || ({1'b0, r_a_st} >= nsp_pkg::STATE_LIMIT)
                || (i_geom.status == '0) || (i_geom.pw == '0) || (i_geom.ph == '0)
                || !in_x || !in_y;
        n_b_mask = i_geom.status[1] && !r_a_opq;
        n_b_base = BB'(r_a_st) * BB'(i_geom.pw);
    end

    always_comb begin
        ax = classify(r_b_dx, i_geom.width, i_geom.cw, i_geom.off_x);
        ay = classify(r_b_dy, i_geom.height, i_geom.ch, i_geom.off_y);
        n_c_side.kill     = r_b_kill;
        n_c_side.use_mask = r_b_mask;
        n_c_side.base     = r_b_base;
        n_c_side.col      = ax.third;
        n_c_side.row      = ay.third;
        n_c_side.edge_x   = ax.edge_src;
        n_c_side.edge_y   = ay.edge_src;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_px   <= i_pixel_x;
            r_a_py   <= i_pixel_y;
            r_a_st   <= i_skin_state;
            r_a_opq  <= i_opaque;
            r_b_dx   <= n_b_dx;
            r_b_dy   <= n_b_dy;
            r_b_kill <= n_b_kill;
            r_b_mask <= n_b_mask;
            r_b_base <= n_b_base;
            r_c_side <= n_c_side;
            r_c_mx   <= ax.m;
            r_c_my   <= ay.m;
        end
    end

    assign o_valid = r_c_v;
    assign o_side  = r_c_side;
    assign o_m_x   = r_c_mx;
    assign o_m_y   = r_c_my;

endmodule

// File: rtl/core/nsp_rem.sv
// Pipelined restoring remainder, one bit per stage, for the x and y middle spans.
// Depends on nsp_pkg; side data travels with each word.
module nsp_rem (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  nsp_pkg::t_side                        i_side,
    input  logic [nsp_pkg::COORD_BITS-1:0]        i_m_x,
    input  logic [nsp_pkg::COORD_BITS-1:0]        i_m_y,
    input  nsp_pkg::t_geom                        i_geom,
    output logic                                  o_valid,
    output nsp_pkg::t_side                        o_side,
    output logic [nsp_pkg::COORD_BITS-1:0]        o_rem_x,
    output logic [nsp_pkg::COORD_BITS-1:0]        o_rem_y
);

    localparam int CB = nsp_pkg::COORD_BITS;
    localparam int NS = nsp_pkg::REM_STAGES;

    logic [NS-1:0]  r_v;
    logic [CB-1:0]  r_rem_x [NS];
    logic [CB-1:0]  r_rem_y [NS];
    logic [CB-1:0]  r_m_x   [NS];
    logic [CB-1:0]  r_m_y   [NS];
    nsp_pkg::t_side r_side  [NS];
    logic [CB-1:0]  n_rem_x [NS];
    logic [CB-1:0]  n_rem_y [NS];
    logic [CB-1:0]  n_m_x   [NS];
    logic [CB-1:0]  n_m_y   [NS];

    // shift in the next dividend bit, subtract the span if it fits
    function automatic logic [CB-1:0] rem_step(input logic [CB-1:0] rem, input logic b,
                                               input logic [CB-1:0] span);
        logic [CB:0] t;
        t = {rem, b};
        if (t >= {1'b0, span}) t = t - {1'b0, span};
        return t[CB-1:0];
    endfunction

    always_comb begin
        n_rem_x[0] = rem_step('0, i_m_x[CB-1], i_geom.span_x);
        n_rem_y[0] = rem_step('0, i_m_y[CB-1], i_geom.span_y);
        n_m_x[0]   = i_m_x << 1;
        n_m_y[0]   = i_m_y << 1;
        for (int s = 1; s < NS; s++) begin
            n_rem_x[s] = rem_step(r_rem_x[s-1], r_m_x[s-1][CB-1], i_geom.span_x);
            n_rem_y[s] = rem_step(r_rem_y[s-1], r_m_y[s-1][CB-1], i_geom.span_y);
            n_m_x[s]   = r_m_x[s-1] << 1;
            n_m_y[s]   = r_m_y[s-1] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_m_x   <= n_m_x;
            r_m_y   <= n_m_y;
            r_side[0] <= i_side;
            for (int s = 1; s < NS; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_rem_x = r_rem_x[NS-1];
    assign o_rem_y = r_rem_y[NS-1];

endmodule

// File: rtl/core/nsp_out.sv
// Result assembly, output register and one-word skid slot; owns the pipeline enable.
// Depends on nsp_pkg; fed by nsp_rem.
module nsp_out (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  nsp_pkg::t_side                        i_side,
    input  logic [nsp_pkg::COORD_BITS-1:0]        i_rem_x,
    input  logic [nsp_pkg::COORD_BITS-1:0]        i_rem_y,
    input  nsp_pkg::t_geom                        i_geom,
    input  logic                                  i_stall,
    output logic                                  o_en,
    output logic                                  o_valid,
    output logic                                  o_covered,
    output logic [nsp_pkg::SRCX_BITS-1:0]         o_source_x,
    output logic [nsp_pkg::COORD_BITS-1:0]        o_source_y,
    output logic                                  o_use_mask,
    output logic [nsp_pkg::ZONE_BITS-1:0]         o_zone
);

    localparam int CB = nsp_pkg::COORD_BITS;
    localparam int XB = nsp_pkg::SRCX_BITS;
    localparam int BB = nsp_pkg::BASE_BITS;
    localparam int ZB = nsp_pkg::ZONE_BITS;

    typedef struct packed {
        logic          covered;
        logic [XB-1:0] source_x;
        logic [CB-1:0] source_y;
        logic          use_mask;
        logic [ZB-1:0] zone;
    } t_result;

    logic          r_out_v, r_skid_v, n_out_v, n_skid_v;
    t_result       r_out, r_skid, n_out, n_skid, res;
    logic          incoming, ok;
    logic [CB-1:0] sx, sy;
    logic [BB-1:0] sum_x;

    assign o_en     = !r_skid_v;
    assign incoming = o_en && i_valid;

    always_comb begin
        sx = (i_side.col == nsp_pkg::THIRD_MID) ? i_geom.cw + i_rem_x : i_side.edge_x;
        sy = (i_side.row == nsp_pkg::THIRD_MID) ? i_geom.ch + i_rem_y : i_side.edge_y;
        // an empty middle span leaves the stretched zones undrawn
        ok = !i_side.kill
            && !((i_side.col == nsp_pkg::THIRD_MID) && (i_geom.span_x == '0))
            && !((i_side.row == nsp_pkg::THIRD_MID) && (i_geom.span_y == '0));
        sum_x = i_side.base + BB'(sx);
        res.covered  = ok;
        res.source_x = ok ? sum_x[XB-1:0] : '0;
        res.source_y = ok ? sy : '0;
        res.use_mask = ok && i_side.use_mask;
        res.zone     = ok ? ZB'(i_side.row) * ZB'(nsp_pkg::ZONE_COLS) + ZB'(i_side.col)
                          : '0;
    end

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (r_out_v && !i_stall) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = incoming;
                n_out   = res;
            end
        end else if (!r_out_v) begin
            n_out_v = incoming;
            n_out   = res;
        end else if (incoming) begin
            n_skid_v = 1'b1;
            n_skid   = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid    = r_out_v;
    assign o_covered  = r_out.covered;
    assign o_source_x = r_out.source_x;
    assign o_source_y = r_out.source_y;
    assign o_use_mask = r_out.use_mask;
    assign o_zone     = r_out.zone;

endmodule

// File: rtl/core/nine_slice_pixel_mapper.sv
// Top level of the nine-slice pixel mapper.
// Depends on nsp_pkg, nsp_cfg, nsp_front, nsp_rem and nsp_out.
//
// Maps each destination pixel of a nine-slice skin draw (tiled edges and
// center) to its source pixel in the skin image, or flags it uncovered.
//
// Channels:
//   input  word  i_pixel_x/i_pixel_y/i_skin_state/i_opaque, taken on an edge
//                with i_in_valid high and o_in_stall low.
//   output word  o_covered/o_source_x/o_source_y/o_use_mask/o_zone, taken on
//                an edge with o_out_valid high and i_out_stall low.
//   config       i_cfg_index/i_cfg_data written on i_cfg_valid; o_cfg_ready
//                is always high. Write only while no pixel is in flight; the
//                clamped corner and span values are registered after the write,
//                corner before span, and are first used by a word two stages deep.
// Throughput: one pixel per clock while the output is not stalled.
// Pipeline: the input word passes three front stages, then the tiling
//   modulo as a 12-stage restoring remainder pipeline (one bit per stage),
//   then the output register.
// Stall: the output word holds; one more result lands in a skid slot, after
//   which o_in_stall rises and the whole pipeline freezes without loss.
// Reset (i_rst_n low at a clock edge): the configuration registers return to
//   zero, the pipeline and skid slot empty, and the block accepts on the
//   next cycle.
module nine_slice_pixel_mapper (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // pixel input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [nsp_pkg::PIX_BITS-1:0]          i_pixel_x,
    input  logic [nsp_pkg::PIX_BITS-1:0]          i_pixel_y,
    input  logic [nsp_pkg::SKIN_BITS-1:0]         i_skin_state,
    input  logic                                  i_opaque,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_covered,
    output logic [nsp_pkg::SRCX_BITS-1:0]         o_source_x,
    output logic [nsp_pkg::COORD_BITS-1:0]        o_source_y,
    output logic                                  o_use_mask,
    output logic [nsp_pkg::ZONE_BITS-1:0]         o_zone,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [nsp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [nsp_pkg::COORD_BITS-1:0]        i_cfg_data
);

    nsp_pkg::t_geom geom;
    nsp_pkg::t_side front_side, rem_side;
    logic           en;
    logic           front_v, rem_v;
    logic [nsp_pkg::COORD_BITS-1:0] m_x, m_y, rem_x, rem_y;

    // Single global enable: it drops only when the skid slot is occupied.
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    nsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_geom  (geom)
    );

    // rectangle test, offsets and zone per axis
    nsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_skin_state (i_skin_state),
        .i_opaque     (i_opaque),
        .i_geom       (geom),
        .o_valid      (front_v),
        .o_side       (front_side),
        .o_m_x        (m_x),
        .o_m_y        (m_y)
    );

    // (offset - corner) mod middle span, both axes side by side
    nsp_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_side  (front_side),
        .i_m_x   (m_x),
        .i_m_y   (m_y),
        .i_geom  (geom),
        .o_valid (rem_v),
        .o_side  (rem_side),
        .o_rem_x (rem_x),
        .o_rem_y (rem_y)
    );

    nsp_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (rem_v),
        .i_side     (rem_side),
        .i_rem_x    (rem_x),
        .i_rem_y    (rem_y),
        .i_geom     (geom),
        .i_stall    (i_out_stall),
        .o_en       (en),
        .o_valid    (o_out_valid),
        .o_covered  (o_covered),
        .o_source_x (o_source_x),
        .o_source_y (o_source_y),
        .o_use_mask (o_use_mask),
        .o_zone     (o_zone)
    );

endmodule

// File: rtl/core/nsp_checker.sv
// Port-level checks for nine_slice_pixel_mapper, attached with bind below.
// Depends on nsp_pkg.
module nsp_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_in_stall,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    input  logic                                  o_covered,
    input  logic [nsp_pkg::SRCX_BITS-1:0]         o_source_x,
    input  logic [nsp_pkg::COORD_BITS-1:0]        o_source_y,
    input  logic                                  o_use_mask,
    input  logic [nsp_pkg::ZONE_BITS-1:0]         o_zone
);

    // uncovered words carry all-zero payload
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_covered |->
            (o_source_x == '0) && (o_source_y == '0) && !o_use_mask && (o_zone == '0))
        else $error("uncovered word with nonzero payload");

    a_zone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_zone <= nsp_pkg::ZONE_LAST))
        else $error("zone out of range");

    // input only backs up once the output holds a word
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_covered) && $stable(o_source_x)
            && $stable(o_source_y) && $stable(o_use_mask) && $stable(o_zone))
        else $error("stalled output word changed");

endmodule

bind nine_slice_pixel_mapper nsp_checker u_nsp_checker (.*);
